// ===== rtl/ngs_pkg.sv =====
// ----------------------------------------------------------------------------
// ngs_pkg
// Types and constants shared by the next-greater-element stack engine.
// ----------------------------------------------------------------------------
package ngs_pkg;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;
    localparam int QUEUE_DEPTH = 2;

    // Input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_sequence;
    } ngs_in_t;

    // Result word
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] next_larger;
        logic                      found;
        logic                      overflow;
        logic                      run_end;
    } ngs_out_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_sequence;
        logic [POS_W-1:0]          position;
        logic                      pos_overflow;
    } ngs_item_t;

    // One stack entry
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } ngs_entry_t;

    // Back-end to output-stage control
    typedef struct packed {
        logic emit;       // new result on emit_data
        logic emit_last;  // that result closes its item
        logic close;      // item done, mark pending result as its last
    } ngs_emit_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_FREAD,
        ST_FLUSH
    } ngs_state_t;

endpackage

// ===== rtl/ngs_front.sv =====
// ----------------------------------------------------------------------------
// ngs_front
// Accepts input words, tags each with its position in the sequence and
// flags positions beyond the supported sequence length.
// ----------------------------------------------------------------------------
module ngs_front import ngs_pkg::*; #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ngs_in_t   s_data,
    input  logic      q_full,
    output logic      q_push,
    output ngs_item_t q_item
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

    logic [CNT_W-1:0]       pos_cnt_reg;
    logic [CNT_W-1:0]       pos_cnt_next;
    logic [CNT_W+POS_W-1:0] pos_ext;
    logic                   pos_ovf;

    // Accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the word
    assign pos_ext = {{POS_W{1'b0}}, pos_cnt_reg};
    assign pos_ovf = (pos_cnt_reg >= MAX_CNT);

    always_comb begin
        q_item.value           = s_data.value;
        q_item.end_of_sequence = s_data.end_of_sequence;
        q_item.position        = pos_ext[POS_W-1:0];
        q_item.pos_overflow    = pos_ovf;
    end

    // Advance position, saturate at the limit, clear at sequence end
    always_comb begin
        pos_cnt_next = pos_cnt_reg;
        if (q_push) begin
            if (s_data.end_of_sequence) begin
                pos_cnt_next = '0;
            end else if (!pos_ovf) begin
                pos_cnt_next = pos_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg <= '0;
        end else begin
            pos_cnt_reg <= pos_cnt_next;
        end
    end

endmodule

// ===== rtl/ngs_queue.sv =====
// ----------------------------------------------------------------------------
// ngs_queue
// Two-entry queue between the front and the stack engine.
// ----------------------------------------------------------------------------
module ngs_queue import ngs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ngs_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output ngs_item_t head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ngs_item_t       entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Store incoming word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

endmodule

// ===== rtl/ngs_back.sv =====
// ----------------------------------------------------------------------------
// ngs_back
// Stack engine: pops smaller entries one per step, pushes or rejects the
// new element, and drains the stack at sequence end.
// ----------------------------------------------------------------------------
module ngs_back import ngs_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  ngs_item_t     q_head,
    output logic          q_pop,
    input  logic          out_ok,
    output ngs_emit_ctl_t emit_ctl,
    output ngs_out_t      emit_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    ngs_entry_t    stack_mem [STACK_DEPTH];
    ngs_entry_t    rd_entry_reg;
    ngs_entry_t    wr_entry;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] top_cnt;

    ngs_state_t    state_reg;
    ngs_state_t    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    ngs_item_t     cur_reg;
    ngs_item_t     cur_next;

    logic          pop_hit;
    logic          reject;
    logic          last_entry;

    // Stack memory, top entry read every cycle
    assign top_cnt = count_reg - CW'(1);
    assign rd_addr = top_cnt[AW-1:0];
    assign wr_addr = count_reg[AW-1:0];

    always_comb begin
        wr_entry.position = cur_reg.position;
        wr_entry.value    = cur_reg.value;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= stack_mem[rd_addr];
    end

    // Decide between pop, reject and push
    assign pop_hit    = (count_reg != '0) &&
                        ($signed(rd_entry_reg.value) < $signed(cur_reg.value));
    assign reject     = cur_reg.pos_overflow || (count_reg == CW'(STACK_DEPTH));
    assign last_entry = (count_reg == CW'(1));

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        emit_ctl   = '0;
        emit_data  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_ok) begin
                    if (pop_hit) begin
                        emit_ctl.emit         = 1'b1;
                        emit_data.position    = rd_entry_reg.position;
                        emit_data.next_larger = cur_reg.value;
                        emit_data.found       = 1'b1;
                        count_next            = count_reg - CW'(1);
                        state_next            = ST_READ;
                    end else if (reject) begin
                        emit_ctl.emit      = 1'b1;
                        emit_ctl.emit_last = !(cur_reg.end_of_sequence && count_reg != '0);
                        emit_data.position = cur_reg.position;
                        emit_data.overflow = 1'b1;
                        if (cur_reg.end_of_sequence && count_reg != '0) begin
                            state_next = ST_FREAD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (cur_reg.end_of_sequence) begin
                            state_next = ST_FREAD;
                        end else begin
                            emit_ctl.close = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_FREAD: begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (out_ok) begin
                    emit_ctl.emit      = 1'b1;
                    emit_ctl.emit_last = last_entry;
                    emit_data.position = rd_entry_reg.position;
                    count_next         = count_reg - CW'(1);
                    state_next         = last_entry ? ST_IDLE : ST_FREAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_emit_close_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(emit_ctl.emit && emit_ctl.close))
        else $error("emit and close in the same cycle");

    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH || state_reg == ST_FREAD) |-> count_reg != '0)
        else $error("drain step with empty stack");

endmodule

// ===== rtl/ngs_out.sv =====
// ----------------------------------------------------------------------------
// ngs_out
// Result stage: holds the newest result until it is known whether it
// closes its item, then moves it to the output register.
// ----------------------------------------------------------------------------
module ngs_out import ngs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  ngs_emit_ctl_t emit_ctl,
    input  ngs_out_t      emit_data,
    output logic          out_ok,
    output logic          m_valid,
    input  logic          m_ready,
    output ngs_out_t      m_data
);

    ngs_out_t m_data_reg;
    logic     m_valid_reg;
    ngs_out_t pend_reg;
    logic     pend_valid_reg;
    logic     pend_last_reg;

    logic     out_free;
    logic     move;
    ngs_out_t move_data;

    assign out_free = !m_valid_reg || m_ready;
    assign out_ok   = !pend_valid_reg || out_free;
    assign move     = pend_valid_reg && out_free &&
                      (pend_last_reg || emit_ctl.emit || emit_ctl.close);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Mark the moving word as last when its item is closed
    always_comb begin
        move_data         = pend_reg;
        move_data.run_end = pend_last_reg || emit_ctl.close;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_data_reg <= move_data;
        end
    end

    // Pending slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end else if (emit_ctl.emit) begin
            pend_valid_reg <= 1'b1;
            pend_last_reg  <= emit_ctl.emit_last;
        end else if (move) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_ctl.emit) begin
            pend_reg <= emit_data;
        end
    end

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_ctl.emit || emit_ctl.close) |-> out_ok)
        else $error("result produced while result stage is blocked");

endmodule

// ===== rtl/next_greater_element_stack.sv =====
// ----------------------------------------------------------------------------
// next_greater_element_stack
// Next-greater-element engine over a monotonic stack of (position, value).
//
//   channel  | direction | word      | handshake
//   ---------+-----------+-----------+------------------
//   s_       | in        | ngs_in_t  | s_valid / s_ready
//   m_       | out       | ngs_out_t | m_valid / m_ready
//
// An element passes ST_IDLE and ST_CHECK, plus ST_READ and ST_CHECK per entry
// it pops; draining at sequence end passes ST_FREAD and ST_FLUSH per entry.
// The read states wait for the stack memory's registered read of the top entry.
// Reset is synchronous, active low, and clears all control state at once.
// A two-entry queue lets the input keep accepting while the engine works or
// the result side stalls; the engine halts while a result cannot move out.
// ----------------------------------------------------------------------------
module next_greater_element_stack import ngs_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_LENGTH  = 1024
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ngs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ngs_out_t m_data
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    ngs_item_t     q_item;
    ngs_item_t     q_head;
    logic          out_ok;
    ngs_emit_ctl_t emit_ctl;
    ngs_out_t      emit_data;

    // Tag and classify incoming words
    ngs_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    // Decouple front from stack engine
    ngs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Stack engine
    ngs_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_ok    (out_ok),
        .emit_ctl  (emit_ctl),
        .emit_data (emit_data)
    );

    // Result stage
    ngs_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .emit_ctl  (emit_ctl),
        .emit_data (emit_data),
        .out_ok    (out_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
